// ===== hw/rtl/cmtc_pkg.sv =====
// Shared types and constants of the cavitation mass-transfer coefficient block.
// No dependencies; every other file imports this package.
package cmtc_pkg;

    localparam int CMTC_QDEPTH = 8;                        // job queue depth
    localparam int CMTC_QAW    = $clog2(CMTC_QDEPTH);      // queue pointer width
    localparam int CMTC_QCW    = $clog2(CMTC_QDEPTH + 1);  // queue fill width
    localparam int CMTC_QBITS  = 47;                       // quotient bits below saturation
    localparam int CMTC_NUMW   = 80;                       // dividend width
    localparam int CMTC_DENW   = 38;                       // divisor width

    localparam logic [47:0] CMTC_POS_MAX  = 48'h7FFF_FFFF_FFFF;
    localparam logic [48:0] CMTC_NEG_MAG  = 49'h0_8000_0000_0000;
    localparam logic [16:0] CMTC_FRAC_ONE = 17'h1_0000;
    localparam logic [6:0]  CMTC_THRESH_INV = 7'd100;
    localparam logic [14:0] CMTC_DEN_SCALE  = 15'd25600;

    typedef enum logic [1:0] {
        CFG_SAT_PRESSURE = 2'd0,
        CFG_COND_COEFF   = 2'd1,
        CFG_VAP_COEFF    = 2'd2
    } t_cfg_idx;

    // One prepared cell: two divisions plus the finished vaporization terms.
    typedef struct packed {
        logic [CMTC_NUMW-1:0] num_a;
        logic [CMTC_DENW-1:0] den_a;
        logic [CMTC_NUMW-1:0] num_p;
        logic [CMTC_DENW-1:0] den_p;
        logic [47:0]          vap_a;
        logic [47:0]          vap_p;
    } t_job;

    typedef struct packed {
        logic [47:0] vap_press;
        logic [47:0] cond_press;
        logic [47:0] vap_alpha;
        logic [47:0] cond_alpha;
    } t_res;

endpackage

// ===== hw/rtl/cmtc_front.sv =====
// Front pipeline: clamps the fraction, forms dp and all products, and emits jobs.
// Depends on cmtc_pkg.
module cmtc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [31:0]   i_pressure,
    input  logic signed [17:0]   i_liquid_fraction,
    input  logic [30:0]          i_sat_pressure,
    input  logic [47:0]          i_cond_coeff,
    input  logic [47:0]          i_vap_coeff,
    output logic                 o_push,
    output cmtc_pkg::t_job       o_job
);
    import cmtc_pkg::*;

    logic [4:0] r_vld;

    // stage 1
    logic [16:0]        r1_a, n1_a;
    logic signed [32:0] r1_dp, n1_dp;
    // stage 2
    logic [32:0] r2_g;
    logic [16:0] r2_a, r2_om;
    logic [37:0] r2_m, n2_m;
    logic [31:0] r2_mag, n2_mag;
    logic [32:0] n2_neg;
    logic        r2_pos, r2_nneg;
    // stage 3
    logic [64:0] r3_ccg_lo;
    logic [48:0] r3_ccg_hi;
    logic [45:0] r3_f;
    logic [48:0] n3_f;
    logic [63:0] r3_cvm_lo;
    logic [47:0] r3_cvm_hi;
    logic [48:0] r3_cva_lo;
    logic [32:0] r3_cva_hi;
    logic [37:0] r3_m;
    logic        r3_pos, r3_nneg;
    // stage 4
    logic [79:0] r4_p;
    logic [80:0] n4_p;
    logic [59:0] r4_fs;
    logic [47:0] r4_va, n4_va, r4_vp, n4_vp;
    logic [79:0] n4_cvm;
    logic [64:0] n4_cva;
    logic [48:0] n4_vmag;
    logic [37:0] r4_m, r4_den, n4_den;
    logic        r4_sel, r4_pos, r4_nneg;
    // stage 5
    logic [62:0] r5_a0, r5_a1;
    logic [46:0] r5_a2;
    logic [63:0] r5_c0;
    logic [59:0] r5_c1;
    logic [47:0] r5_c2;
    logic [43:0] r5_c3;
    logic [47:0] r5_byp, r5_va, r5_vp;
    logic [37:0] r5_den;
    logic        r5_sel, r5_pos, r5_nneg;
    // job assembly
    logic [110:0] n6_sa;
    logic [107:0] n6_sp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_comb begin
        if (i_liquid_fraction[17]) begin
            n1_a = '0;
        end else if (i_liquid_fraction[16:0] > CMTC_FRAC_ONE) begin
            n1_a = CMTC_FRAC_ONE;
        end else begin
            n1_a = i_liquid_fraction[16:0];
        end
        n1_dp = $signed({i_pressure[31], i_pressure}) - $signed({2'b00, i_sat_pressure});
    end

    always_comb begin
        n2_neg = 33'd0 - r1_dp;
        n2_mag = r1_dp[32] ? n2_neg[31:0] : 32'd0;
        n2_m   = r1_dp[32] ? 38'd0
                           : ({6'd0, r1_dp[31:0]} * {31'd0, CMTC_THRESH_INV});
    end

    always_comb begin
        n3_f = {16'd0, r2_g} * {32'd0, r2_om};
    end

    always_comb begin
        n4_p   = {16'd0, r3_ccg_lo} + {r3_ccg_hi, 32'd0};
        n4_cvm = {16'd0, r3_cvm_lo} + {r3_cvm_hi, 32'd0};
        n4_va  = (n4_cvm[79:8] > {24'd0, CMTC_POS_MAX}) ? CMTC_POS_MAX : n4_cvm[55:8];
        n4_cva = {16'd0, r3_cva_lo} + {r3_cva_hi, 32'd0};
        n4_vmag = (n4_cva[64:16] > CMTC_NEG_MAG) ? CMTC_NEG_MAG : n4_cva[64:16];
        n4_vp  = r3_nneg ? 48'd0 : (48'd0 - n4_vmag[47:0]);
        if (r3_m >= {7'd0, i_sat_pressure}) begin
            n4_den = r3_m;
        end else begin
            n4_den = {7'd0, i_sat_pressure};
        end
        // A zero divisor only arises with a zero saturation pressure.
        if (n4_den == 38'd0) begin
            n4_den = 38'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_a  <= n1_a;
        r1_dp <= n1_dp;

        r2_g    <= 33'({17'd0, r1_a} * {17'd0, r1_a});
        r2_a    <= r1_a;
        r2_om   <= CMTC_FRAC_ONE - r1_a;
        r2_m    <= n2_m;
        r2_mag  <= n2_mag;
        r2_pos  <= !r1_dp[32] && (r1_dp != 33'sd0);
        r2_nneg <= !r1_dp[32];

        r3_ccg_lo <= {33'd0, i_cond_coeff[31:0]} * {32'd0, r2_g};
        r3_ccg_hi <= {33'd0, i_cond_coeff[47:32]} * {16'd0, r2_g};
        r3_f      <= n3_f[45:0];
        r3_cvm_lo <= {32'd0, i_vap_coeff[31:0]} * {32'd0, r2_mag};
        r3_cvm_hi <= {32'd0, i_vap_coeff[47:32]} * {16'd0, r2_mag};
        r3_cva_lo <= {17'd0, i_vap_coeff[31:0]} * {32'd0, r2_a};
        r3_cva_hi <= {17'd0, i_vap_coeff[47:32]} * {16'd0, r2_a};
        r3_m      <= r2_m;
        r3_pos    <= r2_pos;
        r3_nneg   <= r2_nneg;

        r4_p    <= n4_p[79:0];
        r4_fs   <= {14'd0, r3_f} * {45'd0, CMTC_DEN_SCALE};
        r4_va   <= n4_va;
        r4_vp   <= n4_vp;
        r4_m    <= r3_m;
        r4_den  <= n4_den;
        r4_sel  <= r3_m >= {7'd0, i_sat_pressure};
        r4_pos  <= r3_pos;
        r4_nneg <= r3_nneg;

        // Below saturation pressure the scaled dp fits in 31 bits.
        r5_a0   <= {31'd0, r4_p[31:0]} * {32'd0, r4_m[30:0]};
        r5_a1   <= {31'd0, r4_p[63:32]} * {32'd0, r4_m[30:0]};
        r5_a2   <= {31'd0, r4_p[79:64]} * {16'd0, r4_m[30:0]};
        r5_c0   <= {32'd0, i_cond_coeff[31:0]} * {32'd0, r4_fs[31:0]};
        r5_c1   <= {28'd0, i_cond_coeff[31:0]} * {32'd0, r4_fs[59:32]};
        r5_c2   <= {32'd0, i_cond_coeff[47:32]} * {16'd0, r4_fs[31:0]};
        r5_c3   <= {28'd0, i_cond_coeff[47:32]} * {16'd0, r4_fs[59:32]};
        r5_byp  <= r4_p[79:32];
        r5_va   <= r4_va;
        r5_vp   <= r4_vp;
        r5_den  <= r4_den;
        r5_sel  <= r4_sel;
        r5_pos  <= r4_pos;
        r5_nneg <= r4_nneg;
    end

    always_comb begin
        n6_sa = {48'd0, r5_a0} + {16'd0, r5_a1, 32'd0} + {r5_a2, 64'd0};
        n6_sp = {44'd0, r5_c0} + {16'd0, r5_c1, 32'd0} + {28'd0, r5_c2, 32'd0}
              + {r5_c3, 64'd0};
        o_job = '0;
        o_job.vap_a = r5_va;
        o_job.vap_p = r5_vp;
        o_job.den_a = 38'd1;
        o_job.den_p = 38'd1;
        if (r5_pos) begin
            // When the scaled dp reaches psat it cancels against the divisor.
            if (r5_sel) begin
                o_job.num_a = {32'd0, r5_byp};
            end else begin
                o_job.num_a = {1'b0, n6_sa[110:32]};
                o_job.den_a = {7'd0, i_sat_pressure};
            end
        end
        if (r5_nneg) begin
            o_job.num_p = {20'd0, n6_sp[107:48]};
            o_job.den_p = r5_den;
        end
    end

    assign o_push = r_vld[4];

endmodule

// ===== hw/rtl/cmtc_fifo.sv =====
// Short job queue between the front pipeline and the divider back end.
// Depends on cmtc_pkg.
module cmtc_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cmtc_pkg::t_job i_job,
    input  logic           i_pop,
    output cmtc_pkg::t_job o_job,
    output logic           o_empty
);
    import cmtc_pkg::*;

    t_job                r_mem [CMTC_QDEPTH];
    logic [CMTC_QAW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CMTC_QCW-1:0] r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + CMTC_QAW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + CMTC_QAW'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + CMTC_QCW'(1);
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - CMTC_QCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_job   = r_mem[r_rd_ptr];
    assign o_empty = (r_fill == '0);

endmodule

// ===== hw/rtl/cmtc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, saturating to 2^47-1.
// Depends on cmtc_pkg.
module cmtc_div (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [cmtc_pkg::CMTC_NUMW-1:0] i_num,
    input  logic [cmtc_pkg::CMTC_DENW-1:0] i_den,
    output logic [47:0]                    o_quo
);
    import cmtc_pkg::*;

    logic [CMTC_DENW-1:0]  r_rem [CMTC_QBITS+1];
    logic [CMTC_QBITS-1:0] r_sh  [CMTC_QBITS+1];
    logic [CMTC_DENW-1:0]  r_den [CMTC_QBITS+1];
    logic                  r_ovf [CMTC_QBITS+1];

    logic [CMTC_DENW-1:0]  n_rem [CMTC_QBITS+1];
    logic [CMTC_QBITS-1:0] n_sh  [CMTC_QBITS+1];
    logic [CMTC_DENW:0]    n_try [CMTC_QBITS+1];
    logic                  n_ovf;
    logic [CMTC_DENW-1:0]  n_top;

    // The quotient fits 47 bits exactly when the dividend's upper part is below D.
    always_comb begin
        n_top = {{(CMTC_DENW - (CMTC_NUMW - CMTC_QBITS)){1'b0}}, i_num[CMTC_NUMW-1:CMTC_QBITS]};
        n_ovf = n_top >= i_den;
        n_rem[0] = n_ovf ? '0 : n_top;
        n_sh[0]  = i_num[CMTC_QBITS-1:0];
        n_try[0] = '0;
        for (int k = 1; k <= CMTC_QBITS; k++) begin
            n_try[k] = {r_rem[k-1], r_sh[k-1][CMTC_QBITS-1]};
            if (n_try[k] >= {1'b0, r_den[k-1]}) begin
                n_try[k] = n_try[k] - {1'b0, r_den[k-1]};
                n_sh[k]  = {r_sh[k-1][CMTC_QBITS-2:0], 1'b1};
            end else begin
                n_sh[k]  = {r_sh[k-1][CMTC_QBITS-2:0], 1'b0};
            end
            n_rem[k] = n_try[k][CMTC_DENW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_rem[0];
            r_sh[0]  <= n_sh[0];
            r_den[0] <= i_den;
            r_ovf[0] <= n_ovf;
            for (int k = 1; k <= CMTC_QBITS; k++) begin
                r_rem[k] <= n_rem[k];
                r_sh[k]  <= n_sh[k];
                r_den[k] <= r_den[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quo = r_ovf[CMTC_QBITS] ? CMTC_POS_MAX : {1'b0, r_sh[CMTC_QBITS]};

endmodule

// ===== hw/rtl/cmtc_back.sv =====
// Back end: pops jobs, runs both divisions in lockstep and holds the result beat.
// Depends on cmtc_pkg and cmtc_div.
module cmtc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  cmtc_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output cmtc_pkg::t_res o_res
);
    import cmtc_pkg::*;

    logic                  r_vld [CMTC_QBITS+1];
    logic [47:0]           r_va  [CMTC_QBITS+1];
    logic [47:0]           r_vp  [CMTC_QBITS+1];
    logic                  r_out_valid;
    t_res                  r_out;
    logic                  w_en;
    logic [47:0]           w_quo_a, w_quo_p;

    // The whole back end holds while a finished beat waits at the output.
    assign w_en  = !r_out_valid || i_ready;
    assign o_pop = w_en && !i_empty;

    cmtc_div u_div_alpha (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (i_job.num_a),
        .i_den (i_job.den_a),
        .o_quo (w_quo_a)
    );

    cmtc_div u_div_press (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (i_job.num_p),
        .i_den (i_job.den_p),
        .o_quo (w_quo_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= CMTC_QBITS; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= !i_empty;
            for (int k = 1; k <= CMTC_QBITS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_valid <= r_vld[CMTC_QBITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_va[0] <= i_job.vap_a;
            r_vp[0] <= i_job.vap_p;
            for (int k = 1; k <= CMTC_QBITS; k++) begin
                r_va[k] <= r_va[k-1];
                r_vp[k] <= r_vp[k-1];
            end
            r_out.cond_alpha <= w_quo_a;
            r_out.vap_alpha  <= r_va[CMTC_QBITS];
            r_out.cond_press <= w_quo_p;
            r_out.vap_press  <= r_vp[CMTC_QBITS];
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

// ===== hw/rtl/cavitation_mass_transfer_coeffs.sv =====
// Top level of the cavitation mass-transfer coefficient block.
// Depends on cmtc_pkg, cmtc_front, cmtc_fifo and cmtc_back.
//
// Usage:
//   Input stream: one beat per mesh cell, pressure (signed Q24.8) and raw
//   liquid fraction (signed Q2.16). Output stream: one beat per cell with
//   the four coefficients, each signed Q16.32 and saturated.
//   Configuration channel: index 0 saturation pressure, 1 condensation
//   coefficient, 2 vaporization coefficient; write only while idle. The
//   channel is always ready; other indexes are ignored.
//   Each accepted input beat reaches its result beat through a five-stage
//   multiply front end, the job queue and a divider that retires one
//   quotient bit per stage.
//   Throughput: one cell per cycle. The input side is throttled by credits
//   for the eight-entry job queue; the divider pipeline and output register
//   hold as a whole while the receiver stalls, and input resumes as soon as
//   credits return.
//   Reset: synchronous and active low; it empties all pipelines and the
//   queue and loads the register reset values (saturation pressure 1.0 Pa).
module cavitation_mass_transfer_coeffs (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [55:0]  i_s_axis_tdata,   // [31:0] pressure, [49:32] liquid_fraction
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [191:0] o_m_axis_tdata,   // [47:0] cond_alpha_term, [95:48] vap_alpha_term,
                                           // [143:96] cond_press_term, [191:144] vap_press_term
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [47:0]  i_cfg_data
);
    import cmtc_pkg::*;

    logic [30:0]         r_sat_pressure;
    logic [47:0]         r_cond_coeff;
    logic [47:0]         r_vap_coeff;
    logic [CMTC_QCW-1:0] r_credit;
    logic                w_accept, w_push, w_pop, w_empty, w_out_valid;
    t_job                w_job_in, w_job_out;
    t_res                w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat_pressure <= 31'd256;
            r_cond_coeff   <= '0;
            r_vap_coeff    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SAT_PRESSURE: r_sat_pressure <= i_cfg_data[30:0];
                CFG_COND_COEFF:   r_cond_coeff   <= i_cfg_data;
                CFG_VAP_COEFF:    r_vap_coeff    <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // Credits cover beats in the front pipeline plus those already queued.
    assign o_s_axis_tready = (r_credit < CMTC_QCW'(CMTC_QDEPTH));
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else if (w_accept && !w_pop) begin
            r_credit <= r_credit + CMTC_QCW'(1);
        end else if (!w_accept && w_pop) begin
            r_credit <= r_credit - CMTC_QCW'(1);
        end
    end

    cmtc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (w_accept),
        .i_pressure        (i_s_axis_tdata[31:0]),
        .i_liquid_fraction (i_s_axis_tdata[49:32]),
        .i_sat_pressure    (r_sat_pressure),
        .i_cond_coeff      (r_cond_coeff),
        .i_vap_coeff       (r_vap_coeff),
        .o_push            (w_push),
        .o_job             (w_job_in)
    );

    cmtc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_empty (w_empty)
    );

    cmtc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_job   (w_job_out),
        .o_pop   (w_pop),
        .o_valid (w_out_valid),
        .i_ready (i_m_axis_tready),
        .o_res   (w_res)
    );

    assign o_m_axis_tvalid = w_out_valid;
    assign o_m_axis_tdata  = w_res;

endmodule
